// ----- design/nsx_pkg.sv -----
// Shared types and constants for the node set crossover unit.
// Used by nsx_ctrl, nsx_datapath and node_set_crossover_unit; no dependencies.
package nsx_pkg;

  localparam int MAX_NODES   = 1024;  // presence map depth
  localparam int MAX_ITEMS   = 32;    // caps a run's results at twice this value
  localparam int NODE_W      = 10;    // node number field width
  localparam int LIMIT_W     = 11;    // node_limit register width
  localparam int COUNT_W     = 6;     // child counter width, saturating
  localparam int CFG_AW      = 3;     // configuration byte address width
  localparam int CFG_DW      = 32;    // configuration data width

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // Register index of node_limit.
  localparam logic REG_NODE_LIMIT = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;    // clear one map entry during the post-reset sweep
    logic load;   // load one transaction into the presence map
    logic start;  // last pair accepted: reset counters and scan address
    logic issue;  // read and clear the next scan address
    logic eval;   // evaluate the entry read in the previous step
    logic flush;  // move the held result out with the run_done mark
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_zero;  // sweep address counter is at entry zero
    logic s1_hold;    // evaluated entry cannot be taken this cycle
    logic pend_v;     // a result is held back waiting for its successor
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

// ----- design/nsx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nsx_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- design/nsx_ctrl.sv -----
// Controller state machine of the node set crossover unit.
// Depends on nsx_pkg for the command and status structs.
module nsx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  nsx_pkg::status_t st,
  output nsx_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_TAIL  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.addr_zero) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        cmd.start = in_tvalid & in_tlast;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.eval  = !st.s1_hold;
        cmd.issue = !st.s1_hold;
        if (!st.s1_hold && st.addr_zero) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.eval = !st.s1_hold;
        if (!st.s1_hold) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = st.pend_v & st.out_free;
        if (!st.pend_v || st.out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/nsx_datapath.sv -----
// Datapath of the node set crossover unit: presence bitmaps, scan pipeline,
// child counters, result hold and output registers. Depends on nsx_pkg and nsx_ram.
module nsx_datapath #(
  parameter int MAX_NODES = nsx_pkg::MAX_NODES,
  parameter int MAX_ITEMS = nsx_pkg::MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nsx_pkg::cmd_t                cmd,
  output nsx_pkg::status_t             st,
  input  logic [nsx_pkg::LIMIT_W-1:0]  node_limit,
  input  logic [nsx_pkg::NODE_W-1:0]   first_node,
  input  logic [nsx_pkg::NODE_W-1:0]   second_node,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nsx_pkg::NODE_W-1:0]   out_node,
  output logic                         out_first,
  output logic                         out_second,
  output logic                         out_last
);

  localparam int NW       = nsx_pkg::NODE_W;
  localparam int CNTW     = nsx_pkg::COUNT_W;
  localparam int AW       = $clog2(MAX_NODES);
  localparam int LW       = (AW + 1 > nsx_pkg::LIMIT_W) ? AW + 1 : nsx_pkg::LIMIT_W;
  localparam int MaxRes   = 2 * MAX_ITEMS;
  localparam int CW       = $clog2(MaxRes + 1);

  logic [LW-1:0]   lim;
  logic [LW-1:0]   first_ext, second_ext;
  logic            first_ok, second_ok;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   s1_addr_r;
  logic            s1_v_r;
  logic            rd_a, rd_b;
  logic            we_a, we_b;
  logic [AW-1:0]   wa_a, wa_b;
  logic [CNTW-1:0] fc_r, fc_nxt, sc_r, sc_nxt;
  logic [CW-1:0]   rcount_r, rcount_nxt;
  logic            emit, to1, to2, fewer, step, move;
  logic            pend_v_r, pend_v_nxt;
  logic [NW-1:0]   pend_node_r;
  logic            pend_f_r, pend_s_r;
  logic            out_v_r, out_v_nxt;
  logic [NW-1:0]   out_node_r;
  logic            out_f_r, out_s_r, out_last_r;

  // Active limit is node_limit clipped to the map depth.
  assign lim = (LW'(node_limit) > LW'(MAX_NODES)) ? LW'(MAX_NODES) : LW'(node_limit);

  assign first_ext  = LW'(first_node);
  assign second_ext = LW'(second_node);
  assign first_ok   = first_ext < lim;
  assign second_ok  = second_ext < lim;

  // One bitmap per parent, so a pair loads with two plain writes.
  assign we_a = cmd.clr | cmd.issue | (cmd.load & first_ok);
  assign we_b = cmd.clr | cmd.issue | (cmd.load & second_ok);
  assign wa_a = cmd.load ? first_ext[AW-1:0] : addr_r;
  assign wa_b = cmd.load ? second_ext[AW-1:0] : addr_r;

  nsx_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_map_first (
    .clk   (clk),
    .we    (we_a),
    .waddr (wa_a),
    .wdata (cmd.load),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (rd_a)
  );

  nsx_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_map_second (
    .clk   (clk),
    .we    (we_b),
    .waddr (wa_b),
    .wdata (cmd.load),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (rd_b)
  );

  // Evaluation of the entry read in the previous step.
  assign emit  = s1_v_r & (rd_a | rd_b) & (LW'(s1_addr_r) < lim) & (rcount_r < CW'(MaxRes));
  assign fewer = fc_r < sc_r;
  assign to1   = (rd_a & rd_b) | ((rd_a ^ rd_b) & fewer);
  assign to2   = (rd_a & rd_b) | ((rd_a ^ rd_b) & !fewer);
  assign step  = cmd.eval & emit;
  assign move  = (step & pend_v_r) | cmd.flush;

  assign st.addr_zero = addr_r == '0;
  assign st.out_free  = !out_v_r | out_ready;
  assign st.s1_hold   = emit & pend_v_r & !st.out_free;
  assign st.pend_v    = pend_v_r;

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.start) begin
      addr_nxt = AW'(MAX_NODES - 1);
    end else if (cmd.clr || cmd.issue) begin
      addr_nxt = addr_r - 1'b1;
    end
  end

  always_comb begin
    fc_nxt     = fc_r;
    sc_nxt     = sc_r;
    rcount_nxt = rcount_r;
    if (cmd.start) begin
      fc_nxt     = '0;
      sc_nxt     = '0;
      rcount_nxt = '0;
    end else if (step) begin
      rcount_nxt = rcount_r + 1'b1;
      if (to1 && fc_r != nsx_pkg::COUNT_MAX) begin
        fc_nxt = fc_r + 1'b1;
      end
      if (to2 && sc_r != nsx_pkg::COUNT_MAX) begin
        sc_nxt = sc_r + 1'b1;
      end
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (step) begin
      pend_v_nxt = 1'b1;
    end else if (cmd.flush) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= AW'(MAX_NODES - 1);
      s1_v_r   <= 1'b0;
      fc_r     <= '0;
      sc_r     <= '0;
      rcount_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      addr_r   <= addr_nxt;
      fc_r     <= fc_nxt;
      sc_r     <= sc_nxt;
      rcount_r <= rcount_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cmd.eval) begin
        s1_v_r <= cmd.issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_addr_r <= addr_r;
    end
    if (step) begin
      pend_node_r <= NW'(s1_addr_r);
      pend_f_r    <= to1;
      pend_s_r    <= to2;
    end
    if (move) begin
      out_node_r <= pend_node_r;
      out_f_r    <= pend_f_r;
      out_s_r    <= pend_s_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid  = out_v_r;
  assign out_node   = out_node_r;
  assign out_first  = out_f_r;
  assign out_second = out_s_r;
  assign out_last   = out_last_r;

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r <= CW'(MaxRes))
    else $error("result count passed its limit");

  a_pend_push: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pend_v_r) |=> (out_v_r && !out_last_r && pend_v_r))
    else $error("held result not pushed out when a newer one arrived");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_v_r && out_last_r && !pend_v_r))
    else $error("final result not marked run_done");

  a_start_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (fc_r == '0 && sc_r == '0 && rcount_r == '0))
    else $error("counters not cleared at scan start");

endmodule

// ----- design/node_set_crossover_unit.sv -----
// Node set crossover unit: top level with the configuration register.
// Each input transaction is loaded into the presence map as it is accepted. The
// transaction with tlast starts a scan of the whole presence map, one entry per cycle
// unless an output stall holds it, from MAX_NODES-1 down to 0; the held last result
// then leaves with run_done. The next input is accepted after that.
// Reset (synchronous, rst_n low) starts a clearing pass over every entry of the
// presence map, during which no input transaction is accepted; configuration writes
// are taken at any time. node_limit resets to 1024, the child counters to zero.
module node_set_crossover_unit #(
  parameter int MAX_NODES = nsx_pkg::MAX_NODES,
  parameter int MAX_ITEMS = nsx_pkg::MAX_ITEMS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,  // [9:0] first_parent_node, [19:10] second_parent_node
  input  logic                        in_tlast,  // last_pair
  // Result stream.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata, // [9:0] child_node
  output logic [1:0]                  out_tuser, // [0] to_first_child, [1] to_second_child
  output logic                        out_tlast, // run_done
  // Configuration port.
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nsx_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [nsx_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [nsx_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NW = nsx_pkg::NODE_W;
  localparam int LW = nsx_pkg::LIMIT_W;

  logic [LW-1:0]    node_limit_r, node_limit_nxt;
  logic             cfg_wr;
  nsx_pkg::cmd_t    cmd;
  nsx_pkg::status_t st;
  logic [NW-1:0]    child_node;

  // The single register sits at byte address 0; bit 2 of the address picks the word.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[2] == nsx_pkg::REG_NODE_LIMIT);
  assign cfg_prdata = (cfg_paddr[2] == nsx_pkg::REG_NODE_LIMIT)
                      ? {{(nsx_pkg::CFG_DW - LW){1'b0}}, node_limit_r} : '0;

  always_comb begin
    node_limit_nxt = node_limit_r;
    if (cfg_wr) begin
      node_limit_nxt = cfg_pwdata[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_limit_r <= nsx_pkg::LIMIT_RESET;
    end else begin
      node_limit_r <= node_limit_nxt;
    end
  end

  // The controller sequences loading, scanning and the final flush.
  nsx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the bitmaps and produces results. One result is held back
  // so that run_done can be set on it once the scan finds no further node.
  nsx_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .node_limit  (node_limit_r),
    .first_node  (in_tdata[NW-1:0]),
    .second_node (in_tdata[2*NW-1:NW]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_node    (child_node),
    .out_first   (out_tuser[0]),
    .out_second  (out_tuser[1]),
    .out_last    (out_tlast)
  );

  assign out_tdata = {{(16 - NW){1'b0}}, child_node};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for node_set_crossover_unit: streams parent node pairs,
// predicts every child placement and checks the result stream field by field.
// Depends on nsx_pkg and the node_set_crossover_unit RTL only.
module tb;

  localparam int MAX_NODES = nsx_pkg::MAX_NODES;
  localparam int NODE_W    = nsx_pkg::NODE_W;
  localparam int LIMIT_W   = nsx_pkg::LIMIT_W;
  localparam int COUNT_W   = nsx_pkg::COUNT_W;
  localparam int CFG_AW    = nsx_pkg::CFG_AW;
  localparam int CFG_DW    = nsx_pkg::CFG_DW;

  // The timeout is far above the slowest legal run. Each of its full-map scans has up
  // to 64 placements that each wait out receiver stalls, and the run has one long
  // hold-off of the receiver.
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int PHASE_PAIRS    = 105;         // minimum loaded transactions per random phase
  localparam int HOLD_CYCLES    = 2000;        // receiver hold-off used to back up the block
  localparam int QUIET_CYCLES   = MAX_NODES + 16;
  localparam logic [CFG_AW-1:0] LIMIT_ADDR = {nsx_pkg::REG_NODE_LIMIT, 2'b00};

  // The scoreboard keeps its own copy of the presence map, the child counters and
  // node_limit. Each accepted pair updates that copy. A pair with tlast replays the
  // scan and queues the placements that the block has to produce, in order.
  class crossover_scoreboard;
    typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              to_first;
      logic              to_second;
      logic              done;
    } placement_t;

    logic [1:0]         presence [MAX_NODES];
    logic [LIMIT_W-1:0] node_limit;
    logic [COUNT_W-1:0] first_count;
    logic [COUNT_W-1:0] second_count;
    placement_t         pending_placements [$];
    int                 mismatches;
    int                 pairs_seen;
    int                 runs_seen;
    int                 placements_checked;

    function new();
      foreach (presence[i]) presence[i] = 2'b00;
      node_limit         = nsx_pkg::LIMIT_RESET;
      first_count        = '0;
      second_count       = '0;
      mismatches         = 0;
      pairs_seen         = 0;
      runs_seen          = 0;
      placements_checked = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] crossover mismatch: %s", $time, what);
    endtask

    function int active_limit();
      return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      node_limit = value;
    endfunction

    function void note_pair(logic [NODE_W-1:0] first_node, logic [NODE_W-1:0] second_node,
                            logic last_pair);
      int         lim;
      int         made;
      logic [1:0] held_map;
      logic       both;
      placement_t p;
      placement_t held;
      lim = active_limit();
      pairs_seen++;
      if (first_node < lim) presence[first_node][0] = 1'b1;
      if (second_node < lim) presence[second_node][1] = 1'b1;
      if (!last_pair) return;
      runs_seen++;
      first_count  = '0;
      second_count = '0;
      made         = 0;
      held         = '0;
      for (int n = lim - 1; n >= 0; n--) begin
        held_map = presence[n];
        // Nodes past the result cap are dropped without touching the counters.
        if (held_map == 2'b00 || made >= 2 * nsx_pkg::MAX_ITEMS) continue;
        both        = (held_map == 2'b11);
        p.node      = NODE_W'(n);
        p.to_first  = both || (first_count < second_count);
        p.to_second = both || !p.to_first;
        p.done      = 1'b0;
        if (p.to_first && first_count != nsx_pkg::COUNT_MAX) first_count++;
        if (p.to_second && second_count != nsx_pkg::COUNT_MAX) second_count++;
        // Hold each placement back one step so the final one can carry run_done.
        if (made > 0) pending_placements.push_back(held);
        held = p;
        made++;
      end
      if (made > 0) begin
        held.done = 1'b1;
        pending_placements.push_back(held);
      end
      // The scan clears the whole map, including entries above the current limit.
      foreach (presence[i]) presence[i] = 2'b00;
    endfunction

    task check_placement(logic [NODE_W-1:0] node, logic to_first, logic to_second,
                         logic done);
      placement_t want;
      if (pending_placements.size() == 0) begin
        report($sformatf("placement of node %0d with none expected", node));
        return;
      end
      want = pending_placements.pop_front();
      placements_checked++;
      if (node !== want.node)
        report($sformatf("child_node %0d, expected %0d", node, want.node));
      if (to_first !== want.to_first)
        report($sformatf("node %0d to_first_child %b, expected %b", want.node, to_first,
                         want.to_first));
      if (to_second !== want.to_second)
        report($sformatf("node %0d to_second_child %b, expected %b", want.node, to_second,
                         want.to_second));
      if (done !== want.done)
        report($sformatf("node %0d run_done %b, expected %b", want.node, done, want.done));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [15:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [CFG_DW-1:0]     cfg_pwdata  = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  crossover_scoreboard   sb = new();

  // Idle rates in percent for the two stream sides. The stimulus sets them per phase.
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  // The stimulus raises pressure_go once. The receiver process then counts out the
  // hold-off itself and marks it done.
  logic                  pressure_go    = 1'b0;
  logic                  pressure_done  = 1'b0;
  int                    cycles         = 0;
  logic [NODE_W-1:0]     run_nodes [$];

  node_set_crossover_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost placement ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d placements outstanding", cycles,
               sb.pending_placements.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result monitor. The values seen at the edge are the ones driven during the cycle
  // before it, so a transaction counts when tvalid and tready were both high.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_placement(out_tdata[NODE_W-1:0], out_tuser[0], out_tuser[1], out_tlast);
  end

  // Receiver. Each cycle it stalls at the phase's rate. One long hold-off backs the
  // scan up, and through it the input stream as well.
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one pair, idling first at the sender's rate, and returns at the edge
  // that accepts it. tvalid stays high into the next call unless that call idles.
  task automatic send_pair(logic [NODE_W-1:0] first_node, logic [NODE_W-1:0] second_node,
                           logic last_pair);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, second_node, first_node};
    in_tlast  <= last_pair;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_pair(first_node, second_node, last_pair);
  endtask

  // One APB transfer with its setup and access phases, after which the bus returns to idle.
  task automatic cfg_access(logic write, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= LIMIT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata       = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected placement has arrived. A scan with an empty union
  // gives no placement, so it then lets a full scan's worth of cycles pass as well.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (sb.pending_placements.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Sets node_limit once the block is idle and reads it back.
  task automatic retune_limit(logic [LIMIT_W-1:0] value);
    logic [CFG_DW-1:0] rd;
    wait_quiet();
    cfg_access(1'b1, CFG_DW'(value), rd);
    sb.set_limit(value);
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DW'(value))
      sb.report($sformatf("node_limit reads %0d after writing %0d", rd, value));
  endtask

  // Limits that matter most come often: zero, one, two, full, oversized and the largest code.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 14) return LIMIT_W'(1);
    if (r < 24) return LIMIT_W'(2);
    if (r < 40) return LIMIT_W'(16);
    if (r < 55) return LIMIT_W'(64);
    if (r < 68) return LIMIT_W'(MAX_NODES);
    if (r < 76) return '1;
    if (r < 84) return LIMIT_W'($urandom_range(2047, MAX_NODES + 1));
    return LIMIT_W'($urandom_range(MAX_NODES, 1));
  endfunction

  // Mostly in-range nodes, with the range ends, repeats within the run and a few
  // nodes that may lie above the limit.
  function automatic logic [NODE_W-1:0] pick_node(int lim);
    int r;
    r = $urandom_range(99);
    if (lim == 0 || r < 6) return NODE_W'($urandom_range(MAX_NODES - 1));
    if (r < 12) return NODE_W'(lim - 1);
    if (r < 16) return '0;
    if (r < 28 && run_nodes.size() != 0)
      return run_nodes[$urandom_range(run_nodes.size() - 1)];
    return NODE_W'($urandom_range(lim - 1));
  endfunction

  initial begin
    logic [CFG_DW-1:0] rd;
    logic [NODE_W-1:0] f;
    logic [NODE_W-1:0] s;
    int                lim;
    int                loaded;
    int                run_len;
    int                run_in_phase;
    int                shared_pct;
    int                r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // node_limit must read back its reset value before anything is written.
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DW'(nsx_pkg::LIMIT_RESET))
      sb.report($sformatf("node_limit reads %0d after reset", rd));

    // Directed part. The first run mixes first-only, second-only and shared nodes and
    // includes both ends of the node range.
    send_pair(10'd1023, 10'd0, 1'b0);
    send_pair(10'd512, 10'd512, 1'b0);
    send_pair(10'd0, 10'd700, 1'b1);
    // The next two runs have one pair each: alternating bit patterns, then the same
    // node from both parents.
    send_pair(10'b0101010101, 10'b1010101010, 1'b1);
    send_pair(10'd1023, 10'd1023, 1'b1);
    // With a zero limit nothing loads, so the scan has an empty union and no run_done.
    retune_limit('0);
    send_pair(10'd3, 10'd4, 1'b1);
    // The smallest nonzero limit. Node 1 is out of range on both sides.
    retune_limit(LIMIT_W'(1));
    send_pair(10'd0, 10'd1, 1'b0);
    send_pair(10'd1, 10'd0, 1'b1);
    // The largest limit code acts as a full map.
    retune_limit('1);
    send_pair(10'd1023, 10'd1022, 1'b1);
    // The limit shrinks between loads. Node 900 is loaded but never scanned. The
    // scan must still clear it, and the run after that checks this.
    retune_limit(LIMIT_W'(MAX_NODES));
    send_pair(10'd900, 10'd10, 1'b0);
    send_pair(10'd11, 10'd900, 1'b0);
    retune_limit(LIMIT_W'(16));
    send_pair(10'd12, 10'd12, 1'b0);
    send_pair(10'd20, 10'd3, 1'b1);
    retune_limit(LIMIT_W'(MAX_NODES));
    send_pair(10'd5, 10'd6, 1'b1);

    // Random part in four phases: no idling, a slow sender, a slow receiver with
    // one long hold-off, and light idling on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      // Phase two opens at the full limit so the hold-off always has placements to
      // back up.
      retune_limit((ph == 0 || ph == 2) ? LIMIT_W'(MAX_NODES) : pick_limit());
      loaded       = 0;
      run_in_phase = 0;
      while (loaded < PHASE_PAIRS) begin
        if (run_in_phase != 0 && $urandom_range(5) == 0) retune_limit(pick_limit());
        r = $urandom_range(99);
        if (r < 80) run_len = $urandom_range(8, 1);
        else if (r < 95) run_len = $urandom_range(32, 9);
        else run_len = $urandom_range(70, 33);
        shared_pct = $urandom_range(60);
        // Phase zero opens with two long runs; the first is at the full limit and has more
        // union nodes than the block gives placements for. The second is almost all
        // shared nodes, so both child counters climb to saturation.
        if (ph == 0 && run_in_phase < 2) begin
          run_len    = 70;
          shared_pct = (run_in_phase == 0) ? 30 : 95;
        end
        if (ph == 2 && run_in_phase == 0) pressure_go = 1'b1;
        lim = sb.active_limit();
        run_nodes.delete();
        for (int k = 0; k < run_len; k++) begin
          f = pick_node(lim);
          s = ($urandom_range(99) < shared_pct) ? f : pick_node(lim);
          run_nodes.push_back(f);
          run_nodes.push_back(s);
          if (f < lim || s < lim) loaded++;
          send_pair(f, s, k == run_len - 1);
        end
        run_in_phase++;
      end
    end

    // A run that ends without tlast would leave no expectation, so every run above is
    // closed. Let the last scan finish and give any stray transaction time to show up.
    wait_quiet();
    if (sb.pending_placements.size() != 0)
      sb.report($sformatf("%0d placements never arrived", sb.pending_placements.size()));

    $display("Covered %0d input transactions in %0d crossover runs; %0d placements checked.",
             sb.pairs_seen, sb.runs_seen, sb.placements_checked);
    $display("Limits from zero to oversized, capped runs and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/nsx_pkg.sv
design/nsx_ram.sv
design/nsx_ctrl.sv
design/nsx_datapath.sv
design/node_set_crossover_unit.sv
dv/tb.sv
